@@ src/cbal_pkg.sv @@
// ============================================================================
// cbal_pkg: shared types and constants for the contiguous block allocator
// Holds the disk geometry, the status and request codes, the scan beat that
// travels along the chain of map cells, and the map update command.
// ============================================================================
package cbal_pkg;

    // Disk geometry.
    localparam int NUM_BLOCKS  = 16;
    localparam int BLOCK_BYTES = 512;

    // Widths; the index and count widths are derived from the geometry.
    localparam int IDX_W  = (NUM_BLOCKS > 2) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
    localparam int LEN_W  = 16;
    localparam int NEED_W = LEN_W + 1;
    localparam int SUM_W  = NEED_W + 1;
    localparam int FIRST_W = 4;
    localparam int START_W = 4;
    localparam int STATUS_W = 2;

    // Request codes carried in tuser.
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } cbal_state_t;

    // Scan beat handed from one map cell to the next.
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [CNT_W-1:0]  count;
        logic [IDX_W-1:0]  start;
        logic [NEED_W-1:0] need;
    } scan_tok_t;

    // Map update command broadcast to every cell for one cycle.
    typedef struct packed {
        logic              en;
        logic              set_free;
        logic [IDX_W-1:0]  lo;
        logic [NEED_W-1:0] need;
    } mark_cmd_t;

    // Run length in blocks: max(1, ceil(length / BLOCK_BYTES)).
    function automatic logic [NEED_W-1:0] run_blocks(input logic [LEN_W-1:0] len);
        logic [NEED_W-1:0] sum;
        logic [NEED_W-1:0] blocks;
        sum    = NEED_W'(len) + NEED_W'(BLOCK_BYTES - 1);
        blocks = NEED_W'(sum / BLOCK_BYTES);
        return (blocks == '0) ? NEED_W'(1) : blocks;
    endfunction

    // The result field carries the low four bits of a block index.
    function automatic logic [START_W-1:0] to_run_start(input logic [IDX_W-1:0] idx);
        logic [IDX_W+START_W-1:0] wide;
        wide = {{START_W{1'b0}}, idx};
        return wide[START_W-1:0];
    endfunction

endpackage

@@ src/contiguous_block_allocator_top.sv @@
// ============================================================================
// contiguous_block_allocator_top: first-fit contiguous block allocator
// Keeps a free map of disk blocks as a chain of cells. An allocate request
// sends a scan beat down the chain to find the first fitting run; a free
// request range-checks and releases a run. One result beat per request.
// ============================================================================
//  channel  | dir | tdata                                  | tuser
//  s_axis   | in  | [15:0] length_bytes, [19:16] first_block | [0] func
//  m_axis   | out | [3:0] run_start                        | [1:0] status
//
//  Allocate: the scan beat is registered in each map cell in turn; as it
//  leaves the last cell the status and run start are captured. Free: they are
//  captured on acceptance. Both load the result register from the result state.
//  The map update is applied at the end of the first cycle in the result
//  state, even while the result register is still busy.
//  Reset marks every block free. A stalled result holds the block in the
//  result state; the request side waits until the result register is free.
// ============================================================================
module contiguous_block_allocator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] length_bytes, [19:16] first_block
    input  logic        s_axis_tuser,   // [0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [3:0] run_start
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import cbal_pkg::*;

    cbal_state_t state_reg;
    cbal_state_t state_next;

    scan_tok_t tok [0:NUM_BLOCKS];
    mark_cmd_t mark_reg;
    mark_cmd_t mark_next;

    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [IDX_W-1:0]    start_reg;
    logic [IDX_W-1:0]    start_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [START_W-1:0]  out_start_reg;

    logic [LEN_W-1:0]   in_len;
    logic [FIRST_W-1:0] in_first;
    logic               in_accept;
    logic               load_out;
    logic [NEED_W-1:0]  in_need;
    logic [SUM_W-1:0]   free_end;
    logic               free_oob;
    scan_tok_t          end_tok;

    // Unpack the request beat.
    assign in_len    = s_axis_tdata[15:0];
    assign in_first  = s_axis_tdata[19:16];
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_need   = run_blocks(in_len);
    assign free_end  = SUM_W'(in_first) + SUM_W'(in_need);
    assign free_oob  = free_end > SUM_W'(NUM_BLOCKS);
    assign end_tok   = tok[NUM_BLOCKS];

    // Scan beat injected at the head of the chain.
    always_comb
    begin
        tok[0].valid = in_accept && (s_axis_tuser == FUNC_ALLOC);
        tok[0].found = 1'b0;
        tok[0].count = '0;
        tok[0].start = '0;
        tok[0].need  = in_need;
    end

    // Chain of map cells.
    for (genvar i = 0; i < NUM_BLOCKS; i++)
    begin : g_cell
        cbal_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .idx    (IDX_W'(i)),
            .tok_in (tok[i]),
            .tok_out(tok[i+1]),
            .mark   (mark_reg)
        );
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (s_axis_tuser == FUNC_ALLOC) ? ST_SCAN : ST_RESULT;
                end
            end
            ST_SCAN:
            begin
                if (end_tok.valid)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the controller: handshake, result capture and map command.
    always_comb
    begin
        s_axis_tready = 1'b0;
        load_out      = 1'b0;
        status_next   = status_reg;
        start_next    = start_reg;
        mark_next     = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (in_accept && (s_axis_tuser == FUNC_FREE))
                begin
                    start_next = '0;
                    if (free_oob)
                    begin
                        status_next = STATUS_RANGE;
                    end
                    else
                    begin
                        status_next        = STATUS_OK;
                        mark_next.en       = 1'b1;
                        mark_next.set_free = 1'b1;
                        mark_next.lo       = IDX_W'(in_first);
                        mark_next.need     = in_need;
                    end
                end
            end
            ST_SCAN:
            begin
                if (end_tok.valid)
                begin
                    if (end_tok.found)
                    begin
                        status_next        = STATUS_OK;
                        start_next         = end_tok.start;
                        mark_next.en       = 1'b1;
                        mark_next.set_free = 1'b0;
                        mark_next.lo       = end_tok.start;
                        mark_next.need     = end_tok.need;
                    end
                    else
                    begin
                        status_next = STATUS_NO_SPACE;
                        start_next  = '0;
                    end
                end
            end
            ST_RESULT:
            begin
                load_out = !out_valid_reg || m_axis_tready;
            end
            default: ;
        endcase
    end

    // Result register valid.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers and the map command.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            mark_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            mark_reg      <= mark_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        start_reg  <= start_next;
        if (load_out)
        begin
            out_status_reg <= status_reg;
            out_start_reg  <= to_run_start(start_reg);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_start_reg};
    assign m_axis_tuser  = out_status_reg;

    // A failed request never reports a start block.
    a_fail_zero_start: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != STATUS_OK)) |-> (m_axis_tdata == 8'd0))
        else $error("non-ok result carries a nonzero start block");

    // A scan beat leaves the chain only while the controller is scanning.
    a_end_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        end_tok.valid |-> (state_reg == ST_SCAN))
        else $error("scan beat left the chain outside the scan state");

    // The map is only updated while the controller is in the result state.
    a_mark_in_result: assert property (@(posedge clk) disable iff (!rst_n)
        mark_reg.en |-> (state_reg == ST_RESULT))
        else $error("map update outside the result state");

    // An accepted request closes the input until its result is produced.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !s_axis_tready)
        else $error("request taken while another is in flight");

endmodule

@@ src/cbal_cell.sv @@
// ============================================================================
// cbal_cell: one disk block of the free map
// Holds the free bit of its block, extends the running free count of the
// first-fit scan by one block per cycle, and applies map update commands.
// ============================================================================
module cbal_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [cbal_pkg::IDX_W-1:0] idx,
    input  cbal_pkg::scan_tok_t       tok_in,
    output cbal_pkg::scan_tok_t       tok_out,
    input  cbal_pkg::mark_cmd_t       mark
);
    import cbal_pkg::*;

    logic      free_reg;
    logic      free_next;
    scan_tok_t tok_reg;
    scan_tok_t tok_next;
    logic      in_range;
    logic [CNT_W-1:0] cnt_inc;

    // Scan step: extend or break the current run of free blocks.
    always_comb
    begin
        cnt_inc  = tok_in.count + CNT_W'(1);
        tok_next = tok_in;
        if (!tok_in.found)
        begin
            if (free_reg)
            begin
                tok_next.count = cnt_inc;
                if (tok_in.count == '0)
                begin
                    tok_next.start = idx;
                end
                if (NEED_W'(cnt_inc) >= tok_in.need)
                begin
                    tok_next.found = 1'b1;
                end
            end
            else
            begin
                tok_next.count = '0;
            end
        end
    end

    // Map update: this block lies in [lo, lo + need).
    always_comb
    begin
        in_range  = (idx >= mark.lo) && (NEED_W'(idx - mark.lo) < mark.need);
        free_next = free_reg;
        if (mark.en && in_range)
        begin
            free_next = mark.set_free;
        end
    end

    // Free bit and scan beat; every block is free after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg <= 1'b1;
            tok_reg  <= '0;
        end
        else
        begin
            free_reg <= free_next;
            tok_reg  <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the contiguous block allocator
// Drives allocate and free requests on the request stream with random gaps,
// predicts each status and run start from a private copy of the free map,
// and compares every result beat with the oldest prediction. Directed cases
// come first, then mixed random traffic and a back-to-back stretch.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cbal_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int MAX_GAP       = 9;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int REPORT_MAX    = 10;

    // One predicted result beat.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [START_W-1:0]  run_start;
    } outcome_t;

    // A run handed out by the allocator that the bench may later release.
    typedef struct packed {
        logic [FIRST_W-1:0] start;
        logic [LEN_W-1:0]   len;
    } live_run_t;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        s_valid = 1'b0;
    logic [23:0] s_data  = '0;
    logic        s_func  = FUNC_ALLOC;
    logic        m_ready = 1'b0;

    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [7:0]  m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    logic [NUM_BLOCKS-1:0] blk_free = '1;
    outcome_t              pending_outcomes[$];
    live_run_t             live_runs[$];
    bit                    idle_on        = 1'b1;
    int                    ready_hold     = 0;
    int                    mismatch_count = 0;
    int                    cycle_count    = 0;
    outcome_t              got_outcome;
    outcome_t              want_outcome;

    contiguous_block_allocator_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_func),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock generation.
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Number of blocks a length occupies, never less than one.
    function automatic int blocks_for(input logic [LEN_W-1:0] len);
        int n;
        n = (int'(len) + BLOCK_BYTES - 1) / BLOCK_BYTES;
        return (n == 0) ? 1 : n;
    endfunction

    // First-fit search or release on the bench's own free map.
    function automatic outcome_t predict_outcome(input logic func,
                                                 input logic [LEN_W-1:0] len,
                                                 input logic [FIRST_W-1:0] first);
        outcome_t res;
        int       need;
        int       run;
        int       base;
        int       i;
        bit       hit;
        res.status    = STATUS_OK;
        res.run_start = '0;
        need = blocks_for(len);
        run  = 0;
        base = 0;
        hit  = 1'b0;
        if (func == FUNC_ALLOC)
        begin
            for (i = 0; i < NUM_BLOCKS && !hit; i++)
            begin
                if (blk_free[i])
                begin
                    run++;
                    if (run >= need)
                    begin
                        base = i + 1 - run;
                        hit  = 1'b1;
                    end
                end
                else
                begin
                    run = 0;
                end
            end
            if (hit)
            begin
                for (i = base; i < base + need; i++)
                    blk_free[i] = 1'b0;
                res.run_start = START_W'(base);
            end
            else
            begin
                res.status = STATUS_NO_SPACE;
            end
        end
        else
        begin
            // A release running past the last block changes nothing.
            if (int'(first) + need > NUM_BLOCKS)
                res.status = STATUS_RANGE;
            else
                for (i = int'(first); i < int'(first) + need; i++)
                    blk_free[i] = 1'b1;
        end
        return res;
    endfunction

    // Lengths weighted toward short runs and block boundaries.
    function automatic logic [LEN_W-1:0] random_length();
        int pick;
        int k;
        pick = $urandom_range(99, 0);
        if (pick < 60)
            return LEN_W'($urandom_range(4 * BLOCK_BYTES, 0));
        if (pick < 80)
        begin
            k = $urandom_range(NUM_BLOCKS, 1);
            return LEN_W'(k * BLOCK_BYTES + $urandom_range(2, 0) - 1);
        end
        if (pick < 90)
            return LEN_W'($urandom_range(NUM_BLOCKS * BLOCK_BYTES, 0));
        return LEN_W'($urandom_range(65535, 0));
    endfunction

    // Send one request beat and record its predicted result on acceptance.
    task automatic send_request(input logic func, input logic [LEN_W-1:0] len,
                                input logic [FIRST_W-1:0] first);
        int       gap;
        outcome_t res;
        gap = idle_on ? $urandom_range(MAX_GAP, 0) : 0;
        if (gap > 0)
        begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {4'b0000, first, len};
        s_func  <= func;
        do
            @(posedge clk);
        while (!s_axis_tready);
        res = predict_outcome(func, len, first);
        pending_outcomes.push_back(res);
        if (func == FUNC_ALLOC && res.status == STATUS_OK)
            live_runs.push_back('{start: res.run_start, len: len});
    endtask

    // Hold off new requests until every predicted result has been seen.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // Mostly allocate and release of runs handed out earlier, some noise.
    task automatic send_random_request();
        int        pick;
        int        idx;
        live_run_t run;
        pick = $urandom_range(99, 0);
        if (pick < 45)
        begin
            send_request(FUNC_ALLOC, random_length(), FIRST_W'($urandom_range(15, 0)));
        end
        else if (pick < 80 && live_runs.size() > 0)
        begin
            idx = $urandom_range(live_runs.size() - 1, 0);
            run = live_runs[idx];
            live_runs.delete(idx);
            send_request(FUNC_FREE, run.len, run.start);
        end
        else
        begin
            send_request(FUNC_FREE, random_length(), FIRST_W'($urandom_range(15, 0)));
        end
    endtask

    task automatic report_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
    endtask

    // Boundary lengths, zero length, full disk, out-of-range and fragmented frees.
    task automatic test_directed();
        idle_on = 1'b1;
        send_request(FUNC_ALLOC, 16'd0, 4'd15);
        send_request(FUNC_ALLOC, 16'd512, 4'd0);
        send_request(FUNC_ALLOC, 16'd513, 4'd9);
        send_request(FUNC_ALLOC, 16'hFFFF, 4'd6);
        send_request(FUNC_FREE, 16'd0, 4'd15);
        send_request(FUNC_FREE, 16'd1024, 4'd15);
        send_request(FUNC_FREE, 16'hFFFF, 4'd0);
        send_request(FUNC_FREE, 16'd8192, 4'd1);
        send_request(FUNC_FREE, 16'd8192, 4'd0);
        send_request(FUNC_ALLOC, 16'd8192, 4'd10);
        send_request(FUNC_ALLOC, 16'd0, 4'd5);
        send_request(FUNC_FREE, 16'd1536, 4'd4);
        send_request(FUNC_ALLOC, 16'd1024, 4'd3);
        send_request(FUNC_ALLOC, 16'd1, 4'd12);
        send_request(FUNC_ALLOC, 16'd1, 4'd0);
        send_request(FUNC_FREE, 16'd8192, 4'd0);
        send_request(FUNC_ALLOC, 16'd511, 4'd7);
        send_request(FUNC_ALLOC, 16'd7680, 4'd1);
        send_request(FUNC_FREE, 16'd512, 4'd2);
        send_request(FUNC_FREE, 16'd1, 4'd8);
        send_request(FUNC_ALLOC, 16'd600, 4'd11);
        send_request(FUNC_ALLOC, 16'hAAAA, 4'd14);
        send_request(FUNC_FREE, 16'd8192, 4'd0);
        wait_for_results();
        live_runs.delete();
    endtask

    // Random traffic with idling switched in stretches and periodic drains.
    task automatic test_random_traffic();
        int n;
        for (n = 0; n < 1500; n++)
        begin
            if (n % 100 == 0)
                idle_on = ($urandom_range(3, 0) != 0);
            send_random_request();
            if (n % 250 == 249)
                wait_for_results();
        end
        wait_for_results();
    endtask

    // Requests and results back to back with no idling on either side.
    task automatic test_streaming();
        int n;
        idle_on = 1'b0;
        for (n = 0; n < 500; n++)
            send_random_request();
        wait_for_results();
        idle_on = 1'b1;
    endtask

    // Result side: random stalls and comparison with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_ready)
            begin
                got_outcome.status    = m_axis_tuser;
                got_outcome.run_start = m_axis_tdata[START_W-1:0];
                if (pending_outcomes.size() == 0)
                begin
                    report_mismatch("unexpected result beat, status", -1,
                                    int'(got_outcome.status));
                end
                else
                begin
                    want_outcome = pending_outcomes.pop_front();
                    if (got_outcome.status != want_outcome.status)
                        report_mismatch("status", int'(want_outcome.status),
                                        int'(got_outcome.status));
                    if (got_outcome.run_start != want_outcome.run_start)
                        report_mismatch("run_start", int'(want_outcome.run_start),
                                        int'(got_outcome.run_start));
                end
                ready_hold = idle_on ? $urandom_range(MAX_GAP, 0) : 0;
            end
            if (ready_hold > 0)
            begin
                m_ready <= 1'b0;
                ready_hold--;
            end
            else
            begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_traffic();
        test_streaming();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_outcomes.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ contiguous_block_allocator_top.f @@
src/cbal_pkg.sv
src/cbal_cell.sv
src/contiguous_block_allocator_top.sv
bench/tb_top.sv
